[rtl/n2seg_pkg.sv]
// Shared types, constants and the segment lookup for the number-to-digits block.
// Depends on nothing; every other file in rtl/ imports it.
package n2seg_pkg;

    // Stream payload widths, each rounded up to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // Field positions inside the input tdata.
    localparam int NUMBER_LSB = 0;
    localparam int START_LSB  = 32;
    localparam int COUNT_LSB  = 35;
    localparam int MODE_LSB   = 39;

    // Display modes.
    localparam logic [2:0] MODE_HEX     = 3'd0;
    localparam logic [2:0] MODE_DEC     = 3'd1;
    localparam logic [2:0] MODE_PAD     = 3'd2;
    localparam logic [2:0] MODE_PAD_DOT = 3'd3;
    localparam logic [2:0] MODE_DEC_DOT = 3'd4;

    // Reciprocal of ten, scaled by two to the 35th, for the digit step.
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Decimal point bit of a segment pattern.
    localparam logic [7:0] SEG_DOT = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take a new item from the input side
        logic step;   // produce one digit into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_work;    // the offered item gives no writes
        logic out_free;   // the output register can take a digit this cycle
        logic step_last;  // the digit being produced ends the item
    } t_status;

    // Seven-segment pattern of one hex digit.
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h39;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage

[rtl/number_to_seven_segment_digits.sv]
// Top level of the number-to-digits block: joins controller and datapath.
// Depends on n2seg_pkg, n2seg_ctrl and n2seg_dp.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata: number[31:0], start_position[34:32], digit_count[38:35],
//           |           |        mode[41:39], zero fill to 48 bits
//  m_axis   | out       | tdata: ram_address[3:0], segments[11:4], zero fill to 16 bits;
//           |           | tlast: final write of the item
//
// An item is accepted, then one digit per cycle, while m_axis does not stall, is produced by the
// shared digit step (divide by ten through the reciprocal, or the low nibble in hex mode), giving
// N writes for an item (N up to MAX_DIGITS). An item that gives no writes ends at its accept.
// The output register lets the next item be accepted while the last write still waits.
// A stall on m_axis holds the digit step; reset is synchronous and active low.
module number_to_seven_segment_digits #(
    parameter int POSITIONS  = 8,
    parameter int MAX_DIGITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // number, start_position, digit_count, mode from the lowest bit up
    input  logic [n2seg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ram_address, segments from the lowest bit up
    output logic [n2seg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);
    import n2seg_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing of accept and digit steps.
    n2seg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Digit arithmetic, position count and output register.
    n2seg_dp #(
        .POSITIONS  (POSITIONS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[rtl/n2seg_ctrl.sv]
// Controller state machine for the number-to-digits block.
// Depends on n2seg_pkg for the command and status structs.
module n2seg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  n2seg_pkg::t_status i_status,
    output n2seg_pkg::t_cmd    o_cmd
);
    import n2seg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // An item is taken only between items; the output register may still be full.
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Issue commands and pick the next state.
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept && !i_status.no_work) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.step_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/n2seg_dp.sv]
// Datapath for the number-to-digits block: digit step, position counter, output register.
// Depends on n2seg_pkg for field positions, modes, command and status structs.
module n2seg_dp #(
    parameter int POSITIONS  = 8,
    parameter int MAX_DIGITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [n2seg_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  n2seg_pkg::t_cmd                       i_cmd,
    output n2seg_pkg::t_status                    o_status,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [n2seg_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic                                  o_out_last
);
    import n2seg_pkg::*;

    localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [4:0]    POS_C   = 5'(POSITIONS);
    localparam logic [4:0]    MAX_C   = 5'(MAX_DIGITS);
    localparam logic [PW-1:0] POS_TOP = PW'(POSITIONS - 1);

    // Input fields.
    logic [31:0] in_number;
    logic [2:0]  in_start;
    logic [3:0]  in_count;
    logic [2:0]  in_mode;

    assign in_number = i_in_data[NUMBER_LSB +: 32];
    assign in_start  = i_in_data[START_LSB +: 3];
    assign in_count  = i_in_data[COUNT_LSB +: 4];
    assign in_mode   = i_in_data[MODE_LSB +: 3];

    // Working registers of the current item.
    logic [31:0]   r_value;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_cnt;
    logic          r_hex;
    logic          r_stop;
    logic          r_dot;
    logic          r_first;

    // Output register.
    logic          r_out_valid;
    logic [3:0]    r_out_addr;
    logic [7:0]    r_out_seg;
    logic          r_out_last;

    // Mode decode of the offered item.
    logic mode_ok;
    logic mode_hex;
    logic mode_stop;
    logic mode_dot;

    always_comb begin
        mode_ok   = 1'b1;
        mode_hex  = 1'b0;
        mode_stop = 1'b0;
        mode_dot  = 1'b0;
        case (in_mode)
            MODE_HEX: begin
                mode_hex  = 1'b1;
                mode_stop = 1'b1;
            end
            MODE_DEC: begin
                mode_stop = 1'b1;
            end
            MODE_PAD: begin
                mode_stop = 1'b0;
            end
            MODE_PAD_DOT: begin
                mode_dot = 1'b1;
            end
            MODE_DEC_DOT: begin
                mode_stop = 1'b1;
                mode_dot  = 1'b1;
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
    end

    // Start position reduced modulo the number of positions.
    logic [4:0] start_mod;

    always_comb begin
        start_mod = {2'b00, in_start};
        for (int k = 0; k < 8; k++) begin
            if (start_mod >= POS_C) begin
                start_mod = start_mod - POS_C;
            end
        end
    end

    // Digit count saturated to the largest allowed.
    logic [4:0] cnt_sat;

    assign cnt_sat = ({1'b0, in_count} > MAX_C) ? MAX_C : {1'b0, in_count};

    // One digit step: low nibble for hex, divide by ten through the reciprocal for decimal.
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [31:0] next_value;
    logic [3:0]  digit;
    logic [7:0]  seg;
    logic [4:0]  pos_ext;

    assign prod       = r_value * RECIP_TEN;
    assign quot       = 32'(prod[63:RECIP_SHIFT]);
    assign rem        = r_value - ((quot << 3) + (quot << 1));
    assign next_value = r_hex ? (r_value >> 4) : quot;
    assign digit      = r_hex ? r_value[3:0] : rem[3:0];
    assign seg        = seg_of(digit) | ((r_dot && r_first) ? SEG_DOT : 8'h00);
    assign pos_ext    = 5'(r_pos);

    // Status toward the controller.
    assign o_status.no_work   = (in_count == 4'd0) || !mode_ok;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.step_last = (r_cnt == CW'(1)) || (r_stop && (next_value == 32'd0));

    // Item registers: loaded on accept, advanced on each digit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= in_number;
            r_pos   <= start_mod[PW-1:0];
            r_cnt   <= CW'(cnt_sat);
            r_hex   <= mode_hex;
            r_stop  <= mode_stop;
            r_dot   <= mode_dot;
            r_first <= 1'b1;
        end else if (i_cmd.step) begin
            r_value <= next_value;
            r_pos   <= (r_pos == '0) ? POS_TOP : r_pos - 1'b1;
            r_cnt   <= r_cnt - 1'b1;
            r_first <= 1'b0;
        end
    end

    // Output register: filled by a step, emptied when its write is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_addr <= {pos_ext[2:0], 1'b0};
            r_out_seg  <= seg;
            r_out_last <= o_status.step_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {4'h0, r_out_seg, r_out_addr};
    assign o_out_last  = r_out_last;

endmodule
